### hw/rtl/mpq_pkg.sv
// Shared types, codes and defaults for the min priority queue.
`default_nettype none
package mpq_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int DATA_BITS_DEF = 16;

    // operation codes
    localparam logic [2:0] OP_ENQUEUE = 3'd0;
    localparam logic [2:0] OP_DEQUEUE = 3'd1;
    localparam logic [2:0] OP_PEEK    = 3'd2;
    localparam logic [2:0] OP_UPDATE  = 3'd3;
    localparam logic [2:0] OP_SEARCH  = 3'd4;
    localparam logic [2:0] OP_CLEAR   = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EXISTS  = 3'd3;
    localparam logic [2:0] ST_MISSING = 3'd4;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] item_value;
        logic signed [15:0] item_priority;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] result_value;
        logic [2:0]         status;
        logic               found;
        logic [4:0]         entry_count;
    } rsp_t;

    // result of the shared compare unit
    typedef struct packed {
        logic eq;   // slot value matches the key value
        logic lt;   // slot priority below the best seen so far
    } cmp_res_t;

endpackage
`default_nettype wire

### hw/rtl/mpq_slot_ram.sv
// Slot store: one write port, one registered read port.
`default_nettype none
module mpq_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/mpq_cmp.sv
// Shared compare unit: value match and signed priority ordering.
`default_nettype none
module mpq_cmp #(
    parameter int DATA_BITS = 16
) (
    input  wire logic [DATA_BITS-1:0] slot_value,
    input  wire logic [DATA_BITS-1:0] slot_priority,
    input  wire logic [DATA_BITS-1:0] key_value,
    input  wire logic [DATA_BITS-1:0] best_priority,
    output mpq_pkg::cmp_res_t         res
);
    import mpq_pkg::*;

    always_comb
    begin
        res.eq = (slot_value == key_value);
        res.lt = ($signed(slot_priority) < $signed(best_priority));
    end

endmodule
`default_nettype wire

### hw/rtl/min_priority_queue.sv
// Min priority queue top level: sequencer around the slot store and compare unit.
//
// One command word is taken when start is high and busy is low; its response
// word appears on result for one cycle with done high and must be taken then.
// Clear, unused codes and the early answers (full, empty, update when empty)
// finish straight from idle. Every other command scans the held entries through
// the single read port of the slot store, one per cycle, an enqueue writing
// its entry in the last scan cycle. Dequeue and a successful update then close
// the gap left by the removed entry, one entry moved per cycle, so a removal at
// index k moves every entry above it down one slot. Entries are kept oldest first.
`default_nettype none
module min_priority_queue #(
    parameter int CAPACITY  = mpq_pkg::CAPACITY_DEF,
    parameter int DATA_BITS = mpq_pkg::DATA_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire mpq_pkg::cmd_t cmd,
    output logic               done,
    output mpq_pkg::rsp_t      result
);
    import mpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = DATA_BITS;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [DW-1:0]   key_val_reg, key_val_next;
    logic [DW-1:0]   key_pri_reg, key_pri_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic            pend_reg, pend_next;
    logic [CW-1:0]   pend_idx_reg, pend_idx_next;
    logic            hit_reg, hit_next;
    logic [CW-1:0]   hit_idx_reg, hit_idx_next;
    logic [DW-1:0]   best_val_reg, best_val_next;
    logic [DW-1:0]   best_pri_reg, best_pri_next;
    logic [CW-1:0]   best_idx_reg, best_idx_next;
    logic            done_reg, done_next;
    rsp_t            rsp_reg, rsp_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [2*DW-1:0] mem_wdata;
    logic            mem_re;
    logic [2*DW-1:0] mem_rdata;
    logic [DW-1:0]   rd_val;
    logic [DW-1:0]   rd_pri;
    cmp_res_t        cmp;

    logic            finish;
    logic [2:0]      fin_status;
    logic [DW-1:0]   fin_value;
    logic            fin_found;
    logic            scan_end;
    logic [CW-1:0]   prev_idx;
    logic [CW-1:0]   last_idx;

    assign rd_val = mem_rdata[2*DW-1:DW];
    assign rd_pri = mem_rdata[DW-1:0];

    mpq_slot_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (2 * DW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    mpq_cmp #(
        .DATA_BITS (DW)
    ) u_cmp (
        .slot_value    (rd_val),
        .slot_priority (rd_pri),
        .key_value     (key_val_reg),
        .best_priority (best_pri_reg),
        .res           (cmp)
    );

    assign scan_end = (rd_idx_reg == count_reg) && !pend_reg;
    assign prev_idx = pend_idx_reg - CW'(1);
    assign last_idx = count_reg - CW'(1);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_val_next  = key_val_reg;
        key_pri_next  = key_pri_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        best_val_next = best_val_reg;
        best_pri_next = best_pri_reg;
        best_idx_next = best_idx_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        finish        = 1'b0;
        fin_status    = ST_OK;
        fin_value     = '0;
        fin_found     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = cmd.opcode;
                    key_val_next = DW'($unsigned(cmd.item_value));
                    key_pri_next = DW'($unsigned(cmd.item_priority));
                    rd_idx_next  = '0;
                    pend_next    = 1'b0;
                    hit_next     = 1'b0;
                    case (cmd.opcode)
                        OP_ENQUEUE:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                finish     = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_DEQUEUE, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                finish     = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (count_reg == '0)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_SEARCH:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            finish     = 1'b1;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    mem_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (cmp.eq && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = pend_idx_reg;
                    end
                    // strict less keeps the oldest among equal priorities
                    if (pend_idx_reg == '0 || cmp.lt)
                    begin
                        best_val_next = rd_val;
                        best_pri_next = rd_pri;
                        best_idx_next = pend_idx_reg;
                    end
                end

                if (scan_end)
                begin
                    case (op_reg)
                        OP_ENQUEUE:
                        begin
                            finish = 1'b1;
                            if (hit_reg)
                            begin
                                fin_status = ST_EXISTS;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = {key_val_reg, key_pri_reg};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_SEARCH:
                        begin
                            finish    = 1'b1;
                            fin_found = hit_reg;
                        end
                        OP_PEEK:
                        begin
                            finish    = 1'b1;
                            fin_value = best_val_reg;
                        end
                        OP_DEQUEUE:
                        begin
                            state_next  = S_SHIFT;
                            rd_idx_next = best_idx_reg + CW'(1);
                        end
                        OP_UPDATE:
                        begin
                            if (hit_reg)
                            begin
                                state_next  = S_SHIFT;
                                rd_idx_next = hit_idx_reg + CW'(1);
                            end
                            else
                            begin
                                finish     = 1'b1;
                                fin_status = ST_MISSING;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    mem_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                    rd_idx_next   = rd_idx_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // entry read last cycle moves down one slot
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = prev_idx[AW-1:0];
                    mem_wdata = mem_rdata;
                end

                if (scan_end)
                begin
                    finish = 1'b1;
                    if (op_reg == OP_UPDATE)
                    begin
                        // re-enter as newest arrival; count unchanged
                        mem_we    = 1'b1;
                        mem_waddr = last_idx[AW-1:0];
                        mem_wdata = {key_val_reg, key_pri_reg};
                    end
                    else
                    begin
                        fin_value  = best_val_reg;
                        count_next = last_idx;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = S_IDLE;
        end

        done_next = finish;
        rsp_next  = rsp_reg;
        if (finish)
        begin
            rsp_next.result_value = 16'(fin_value);
            rsp_next.status       = fin_status;
            rsp_next.found        = fin_found;
            rsp_next.entry_count  = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_val_reg  <= key_val_next;
        key_pri_reg  <= key_pri_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        best_val_reg <= best_val_next;
        best_pri_reg <= best_pri_next;
        best_idx_reg <= best_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

endmodule
`default_nettype wire
